### rtl/dual_reload_down_timer_defines.svh
// Assertion macros for the dual reload down timer.
// Used by the top level only; no other dependencies.
`ifndef DUAL_RELOAD_DOWN_TIMER_DEFINES_SVH
`define DUAL_RELOAD_DOWN_TIMER_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define DRDT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("drdt same-cycle check failed");

// next-cycle implication under synchronous active-low reset
`define DRDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("drdt next-cycle check failed");

`endif

### rtl/drdt_pkg.sv
// Shared types and constants for the dual reload down timer.
// No dependencies; imported by every module of the block.
package drdt_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int WORD_W            = 32;
    localparam int KIND_W            = 2;
    localparam int SEL_W             = 3;
    localparam int CTL_W             = 6;
    localparam int IRQ_W             = 2;
    localparam int S_TUSER_W         = KIND_W + SEL_W;
    localparam int M_TDATA_W         = ((WORD_W + IRQ_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    localparam logic [SEL_W-1:0] REG_T1_COUNT  = 3'd0;
    localparam logic [SEL_W-1:0] REG_T1_RELOAD = 3'd1;
    localparam logic [SEL_W-1:0] REG_T2_COUNT  = 3'd2;
    localparam logic [SEL_W-1:0] REG_T2_RELOAD = 3'd3;
    localparam logic [SEL_W-1:0] REG_CONTROL   = 3'd4;
    localparam logic [SEL_W-1:0] REG_STATUS    = 3'd5;
    localparam logic [SEL_W-1:0] REG_MASK      = 3'd6;

    localparam int CTL_T1_EN     = 0;
    localparam int CTL_T1_RELOAD = 1;
    localparam int CTL_T2_EN     = 3;
    localparam int CTL_T2_RELOAD = 4;

    localparam int IRQ_T1 = 0;
    localparam int IRQ_T2 = 1;

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic              irq2;
        logic              irq1;
        logic [WORD_W-1:0] read_data;
    } result_t;

    typedef struct packed {
        logic [IRQ_W-1:0] status;
        logic [IRQ_W-1:0] mask;
    } irq_view_t;

endpackage

### rtl/dual_reload_down_timer.sv
// Top level of the dual reload down timer: input register, core, result register.
// Depends on drdt_pkg, drdt_in_stage, drdt_core, drdt_out_stage and the defines header.
//
//   channel | dir | tdata                          | tuser
//   s_      | in  | [31:0] write_data               | [1:0] kind, [4:2] reg_select
//   m_      | out | [31:0] read_data, [32] timer1_irq, [33] timer2_irq | -
//
// One beat per cycle while m_tready is high; beats pass input then result register.
// Each beat is executed against the timer state in the cycle it leaves the input
// register; ticks, reads and writes are all handled in that cycle.
// Reset (aresetn low, synchronous) clears counters, reloads, control and status
// and masks both interrupts.
// A stalled m_ side holds one result and one more accepted beat, then drops s_tready.
`include "dual_reload_down_timer_defines.svh"

module dual_reload_down_timer #(
    parameter int COUNTER_WIDTH = drdt_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [drdt_pkg::WORD_W-1:0]       s_tdata,   // [31:0] write_data
    input  logic [drdt_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] kind, [4:2] reg_select
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [drdt_pkg::M_TDATA_W-1:0]    m_tdata    // [31:0] read_data,
                                                         // [32] timer1_irq, [33] timer2_irq
);
    import drdt_pkg::*;

    item_t     s_item;
    item_t     item;
    logic      item_valid;
    logic      load_ready;
    logic      fire;
    result_t   result;
    result_t   m_result;
    irq_view_t view;

    assign s_item.data = s_tdata;
    assign s_item.kind = s_tuser[KIND_W-1:0];
    assign s_item.sel  = s_tuser[S_TUSER_W-1:KIND_W];
    assign fire        = item_valid && load_ready;

    drdt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    drdt_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .result  (result),
        .view    (view)
    );

    drdt_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .result     (result),
        .load_ready (load_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    assign m_tdata = M_TDATA_W'(m_result);

    `DRDT_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, fire, m_tvalid)
    `DRDT_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn, s_tvalid && s_tready, item_valid)
    `DRDT_ASSERT_NEXT(a_status_rises_on_tick_only, aclk, aresetn,
        !(fire && item.kind == KIND_TICK), (view.status & ~$past(view.status)) == '0)
    `DRDT_ASSERT_NOW(a_mask_set_after_reset, aclk, aresetn, !$past(aresetn), view.mask == '1)

endmodule

### rtl/drdt_in_stage.sv
// Input register for the dual reload down timer: holds one accepted beat.
// Depends on drdt_pkg.
module drdt_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  drdt_pkg::item_t s_item,
    input  logic           fire,
    output logic           item_valid,
    output drdt_pkg::item_t item
);
    import drdt_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || fire;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/drdt_core.sv
// Timer state and per-beat execution: ticks, register reads and writes.
// Depends on drdt_pkg.
module drdt_core #(
    parameter int COUNTER_WIDTH = drdt_pkg::COUNTER_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  drdt_pkg::item_t    item,
    output drdt_pkg::result_t  result,
    output drdt_pkg::irq_view_t view
);
    import drdt_pkg::*;

    localparam int CW = COUNTER_WIDTH;

    logic [CW-1:0]    t1_count_reg,  t1_count_next;
    logic [CW-1:0]    t1_reload_reg, t1_reload_next;
    logic [CW-1:0]    t2_count_reg,  t2_count_next;
    logic [CW-1:0]    t2_reload_reg, t2_reload_next;
    logic [CTL_W-1:0] ctl_reg,       ctl_next;
    logic [IRQ_W-1:0] status_reg,    status_next;
    logic [IRQ_W-1:0] mask_reg,      mask_next;

    always_comb begin
        t1_count_next  = t1_count_reg;
        t1_reload_next = t1_reload_reg;
        t2_count_next  = t2_count_reg;
        t2_reload_next = t2_reload_reg;
        ctl_next       = ctl_reg;
        status_next    = status_reg;
        mask_next      = mask_reg;
        result         = '0;
        unique case (item.kind)
            KIND_TICK: begin
                if (ctl_reg[CTL_T1_EN]) begin
                    if (t1_count_reg == '0) begin
                        status_next[IRQ_T1] = 1'b1;
                        if (ctl_reg[CTL_T1_RELOAD]) begin
                            t1_count_next = t1_reload_reg;
                        end
                    end else begin
                        t1_count_next = t1_count_reg - CW'(1);
                    end
                end
                if (ctl_reg[CTL_T2_EN]) begin
                    if (t2_count_reg == '0) begin
                        status_next[IRQ_T2] = 1'b1;
                        if (ctl_reg[CTL_T2_RELOAD]) begin
                            t2_count_next = t2_reload_reg;
                        end
                    end else begin
                        t2_count_next = t2_count_reg - CW'(1);
                    end
                end
            end
            KIND_READ: begin
                unique case (item.sel)
                    REG_T1_COUNT:  result.read_data = WORD_W'(t1_count_reg);
                    REG_T1_RELOAD: result.read_data = WORD_W'(t1_reload_reg);
                    REG_T2_COUNT:  result.read_data = WORD_W'(t2_count_reg);
                    REG_T2_RELOAD: result.read_data = WORD_W'(t2_reload_reg);
                    REG_CONTROL:   result.read_data = WORD_W'(ctl_reg);
                    REG_STATUS:    result.read_data = WORD_W'(status_reg);
                    REG_MASK:      result.read_data = WORD_W'(mask_reg);
                    default:       result.read_data = '0;
                endcase
            end
            KIND_WRITE: begin
                unique case (item.sel)
                    REG_T1_COUNT:  t1_count_next  = CW'(item.data);
                    REG_T1_RELOAD: t1_reload_next = CW'(item.data);
                    REG_T2_COUNT:  t2_count_next  = CW'(item.data);
                    REG_T2_RELOAD: t2_reload_next = CW'(item.data);
                    REG_CONTROL:   ctl_next       = item.data[CTL_W-1:0];
                    REG_STATUS:    status_next    = status_reg & ~item.data[IRQ_W-1:0];
                    REG_MASK:      mask_next      = item.data[IRQ_W-1:0];
                    default:       ;
                endcase
            end
            default: ;
        endcase
        result.irq1 = status_next[IRQ_T1] & ~mask_next[IRQ_T1];
        result.irq2 = status_next[IRQ_T2] & ~mask_next[IRQ_T2];
    end

    assign view.status = status_reg;
    assign view.mask   = mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_count_reg  <= '0;
            t1_reload_reg <= '0;
            t2_count_reg  <= '0;
            t2_reload_reg <= '0;
            ctl_reg       <= '0;
            status_reg    <= '0;
            mask_reg      <= '1;
        end else if (fire) begin
            t1_count_reg  <= t1_count_next;
            t1_reload_reg <= t1_reload_next;
            t2_count_reg  <= t2_count_next;
            t2_reload_reg <= t2_reload_next;
            ctl_reg       <= ctl_next;
            status_reg    <= status_next;
            mask_reg      <= mask_next;
        end
    end

endmodule

### rtl/drdt_out_stage.sv
// Result register for the dual reload down timer: holds one beat for the sink.
// Depends on drdt_pkg.
module drdt_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  drdt_pkg::result_t result,
    output logic              load_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output drdt_pkg::result_t m_result
);
    import drdt_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign load_ready = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= load;
        end
        if (load) begin
            result_reg <= result;
        end
    end

endmodule
